// ===== hw/rtl/row_wave_alpha_and_contrast_assert.svh =====
// Assertion macros shared by the row wave alpha and contrast RTL.
`ifndef ROW_WAVE_ALPHA_AND_CONTRAST_ASSERT_SVH
`define ROW_WAVE_ALPHA_AND_CONTRAST_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RWAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RWAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rwac_pkg.sv =====
// Package: shared types, register map and constants for the row wave alpha block.
`timescale 1ns / 1ps

package rwac_pkg;

  localparam int DEF_MAX_DIM     = 4096;
  localparam int DEF_SINE_DEPTH  = 1024;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_WAVE_FREQUENCY = 3'd2,
    REG_WAVE_PHASE     = 3'd3,
    REG_LEVEL_A        = 3'd4,
    REG_LEVEL_B        = 3'd5,
    REG_CONTRAST_GAIN  = 3'd6,
    REG_WAVE_SHAPE     = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    MODE_SINE   = 3'd0,
    MODE_COS2   = 3'd1,
    MODE_COS8   = 3'd2,
    MODE_COS20  = 3'd3,
    MODE_SQUARE = 3'd4
  } wave_shape_t;

  typedef enum logic [3:0] {
    WV_IDLE,
    WV_DIV,
    WV_RDCOS,
    WV_RDSIN,
    WV_SINCAP,
    WV_M4,
    WV_M8,
    WV_M16,
    WV_M20,
    WV_ALPHA
  } wave_state_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [15:0] wave_frequency;
    logic [15:0] wave_phase;
    logic [7:0]  level_a;
    logic [7:0]  level_b;
    logic [15:0] contrast_gain;
    logic [2:0]  wave_shape;
  } cfg_t;

endpackage

// ===== hw/rtl/rwac_in_if.sv =====
// Pixel input channel: valid/ready handshake with RGB payload.
`timescale 1ns / 1ps

interface rwac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// ===== hw/rtl/rwac_out_if.sv =====
// Pixel result channel: valid/ready handshake with alpha, RGB and framing flags.
`timescale 1ns / 1ps

interface rwac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       end_of_row;
  logic       end_of_frame;

  modport source (output valid, output alpha_out, output red_out, output green_out,
                  output blue_out, output end_of_row, output end_of_frame,
                  input ready);
  modport sink   (input valid, input alpha_out, input red_out, input green_out,
                  input blue_out, input end_of_row, input end_of_frame,
                  output ready);
endinterface

// ===== hw/rtl/rwac_cfg.sv =====
// APB register file holding the block configuration.
`timescale 1ns / 1ps

module rwac_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rwac_pkg::ADDR_W-1:0] paddr,
  input  logic [rwac_pkg::DATA_W-1:0] pwdata,
  output logic [rwac_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rwac_pkg::cfg_t              cfg
);

  rwac_pkg::cfg_t cfg_r;
  rwac_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        rwac_pkg::REG_FRAME_WIDTH:    cfg_nxt.frame_width    = pwdata[12:0];
        rwac_pkg::REG_FRAME_HEIGHT:   cfg_nxt.frame_height   = pwdata[12:0];
        rwac_pkg::REG_WAVE_FREQUENCY: cfg_nxt.wave_frequency = pwdata[15:0];
        rwac_pkg::REG_WAVE_PHASE:     cfg_nxt.wave_phase     = pwdata[15:0];
        rwac_pkg::REG_LEVEL_A:        cfg_nxt.level_a        = pwdata[7:0];
        rwac_pkg::REG_LEVEL_B:        cfg_nxt.level_b        = pwdata[7:0];
        rwac_pkg::REG_CONTRAST_GAIN:  cfg_nxt.contrast_gain  = pwdata[15:0];
        rwac_pkg::REG_WAVE_SHAPE:     cfg_nxt.wave_shape     = pwdata[2:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= 13'd1;
      cfg_r.frame_height   <= 13'd1;
      cfg_r.wave_frequency <= 16'd256;
      cfg_r.wave_phase     <= 16'd0;
      cfg_r.level_a        <= 8'd0;
      cfg_r.level_b        <= 8'd255;
      cfg_r.contrast_gain  <= 16'd256;
      cfg_r.wave_shape     <= rwac_pkg::MODE_SINE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      rwac_pkg::REG_FRAME_WIDTH:    prdata = {19'd0, cfg_r.frame_width};
      rwac_pkg::REG_FRAME_HEIGHT:   prdata = {19'd0, cfg_r.frame_height};
      rwac_pkg::REG_WAVE_FREQUENCY: prdata = {16'd0, cfg_r.wave_frequency};
      rwac_pkg::REG_WAVE_PHASE:     prdata = {16'd0, cfg_r.wave_phase};
      rwac_pkg::REG_LEVEL_A:        prdata = {24'd0, cfg_r.level_a};
      rwac_pkg::REG_LEVEL_B:        prdata = {24'd0, cfg_r.level_b};
      rwac_pkg::REG_CONTRAST_GAIN:  prdata = {16'd0, cfg_r.contrast_gain};
      rwac_pkg::REG_WAVE_SHAPE:     prdata = {29'd0, cfg_r.wave_shape};
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/rwac_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, keeps the low quotient bits.
`timescale 1ns / 1ps

module rwac_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 13,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r,  rem_nxt;
  logic [DVD_W-1:0] dvd_r,  dvd_nxt;
  logic [Q_W-1:0]   quo_r,  quo_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      quo_nxt = {quo_r[Q_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/rwac_wave.sv =====
// Row wave sequencer: row position divide, quarter-wave ROM reads, shared multiplier.
`timescale 1ns / 1ps

module rwac_wave #(
  parameter int MAX_DIM          = rwac_pkg::DEF_MAX_DIM,
  parameter int SINE_TABLE_DEPTH = rwac_pkg::DEF_SINE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(MAX_DIM)-1:0]          row,
  input  logic [$clog2(MAX_DIM+1)-1:0]        height,
  input  rwac_pkg::cfg_t                      cfg,
  output logic                                done,
  output logic [7:0]                          alpha
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int DVD_W = CNT_W + 24;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TERM_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210};

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH];

  // Quarter-wave table, sin(pi/2 * k/DEPTH) in 0.16, from a Q30 Taylor series.
  function automatic rom_t build_rom();
    rom_t               t;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        e;
    logic signed [63:0] sum;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TERM_DIV[n-1];
        if ((n & 1) != 0) sum = sum - $signed(term);
        else              sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      e = ($unsigned(sum) + 64'd8192) >> 14;
      if (e > 64'd65535) e = 64'd65535;
      t[k] = e[15:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  rwac_pkg::wave_state_t state_r, state_nxt;

  logic [DIM_W-1:0]  h_r, h_nxt;
  logic [15:0]       a_r, a_nxt;
  logic [16:0]       c2_r, c2_nxt;
  logic [16:0]       sh_r, sh_nxt;
  logic [16:0]       c4_r, c4_nxt;
  logic [16:0]       c8_r, c8_nxt;
  logic [16:0]       c16_r, c16_nxt;
  logic [16:0]       c20_r, c20_nxt;
  logic              cpos_r, cpos_nxt;
  logic [7:0]        alpha_r, alpha_nxt;
  logic              done_r, done_nxt;

  logic [15:0]       rom_q_r;
  logic              rd_full_r;
  logic              rd_neg_r;

  logic [CNT_W+15:0] row_freq;
  logic              div_done;
  logic [15:0]       div_quo;

  logic [15:0]       ang;
  logic [14:0]       ang_u;
  logic [31:0]       idx_prod;
  logic [31:0]       idx_full;
  logic              ang_full;
  logic [IDX_W-1:0]  rom_addr;

  logic [16:0]       q_val;
  logic [17:0]       half_sum;
  logic [16:0]       half;

  logic [16:0]       mul_a, mul_b;
  logic [33:0]       mul_p;
  logic [16:0]       mul_q;
  logic [16:0]       w_sel;
  logic [7:0]        lo;
  logic [7:0]        range;

  assign row_freq = (CNT_W+16)'(row) * (CNT_W+16)'(cfg.wave_frequency);

  rwac_div #(
    .DVD_W (DVD_W),
    .DVS_W (DIM_W),
    .Q_W   (16)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start && (state_r == rwac_pkg::WV_IDLE)),
    .dividend ({row_freq, 8'h00}),
    .divisor  (h_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Cosine is read first at angle a + quarter turn, then sine at a.
  assign ang      = (state_r == rwac_pkg::WV_RDCOS) ? a_r + 16'h4000 : a_r;
  assign ang_u    = ang[14] ? 15'h4000 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
  assign idx_prod = {17'd0, ang_u} * 32'(SINE_TABLE_DEPTH);
  assign idx_full = idx_prod >> 14;
  assign ang_full = idx_full >= 32'(SINE_TABLE_DEPTH);
  assign rom_addr = idx_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    rom_q_r   <= SINE_ROM[rom_addr];
    rd_full_r <= ang_full;
    rd_neg_r  <= ang[15];
  end

  assign q_val    = rd_full_r ? 17'h10000 : {1'b0, rom_q_r};
  assign half_sum = rd_neg_r ? 18'h10000 - {1'b0, q_val} : 18'h10000 + {1'b0, q_val};
  assign half     = half_sum[17:1];

  assign lo    = (cfg.level_a < cfg.level_b) ? cfg.level_a : cfg.level_b;
  assign range = (cfg.level_a < cfg.level_b) ? cfg.level_b - cfg.level_a
                                             : cfg.level_a - cfg.level_b;

  always_comb begin
    case (cfg.wave_shape)
      rwac_pkg::MODE_SINE:   w_sel = sh_r;
      rwac_pkg::MODE_COS2:   w_sel = c2_r;
      rwac_pkg::MODE_COS8:   w_sel = c8_r;
      rwac_pkg::MODE_COS20:  w_sel = c20_r;
      rwac_pkg::MODE_SQUARE: w_sel = cpos_r ? 17'h10000 : 17'd0;
      default:               w_sel = 17'd0;
    endcase
  end

  always_comb begin
    case (state_r)
      rwac_pkg::WV_M4: begin
        mul_a = c2_r;
        mul_b = c2_r;
      end
      rwac_pkg::WV_M8: begin
        mul_a = c4_r;
        mul_b = c4_r;
      end
      rwac_pkg::WV_M16: begin
        mul_a = c8_r;
        mul_b = c8_r;
      end
      rwac_pkg::WV_M20: begin
        mul_a = c16_r;
        mul_b = c4_r;
      end
      rwac_pkg::WV_ALPHA: begin
        mul_a = w_sel;
        mul_b = {9'd0, range};
      end
      default: begin
        mul_a = 17'd0;
        mul_b = 17'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign mul_q = mul_p[32:16];

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    a_nxt     = a_r;
    c2_nxt    = c2_r;
    sh_nxt    = sh_r;
    c4_nxt    = c4_r;
    c8_nxt    = c8_r;
    c16_nxt   = c16_r;
    c20_nxt   = c20_r;
    cpos_nxt  = cpos_r;
    alpha_nxt = alpha_r;
    done_nxt  = 1'b0;
    case (state_r)
      rwac_pkg::WV_IDLE: begin
        if (start) begin
          h_nxt     = height;
          state_nxt = rwac_pkg::WV_DIV;
        end
      end
      rwac_pkg::WV_DIV: begin
        if (div_done) begin
          a_nxt     = div_quo - cfg.wave_phase;
          state_nxt = rwac_pkg::WV_RDCOS;
        end
      end
      rwac_pkg::WV_RDCOS: state_nxt = rwac_pkg::WV_RDSIN;
      rwac_pkg::WV_RDSIN: begin
        c2_nxt    = half;
        cpos_nxt  = !rd_neg_r && (q_val != 17'd0);
        state_nxt = rwac_pkg::WV_SINCAP;
      end
      rwac_pkg::WV_SINCAP: begin
        sh_nxt    = half;
        state_nxt = rwac_pkg::WV_M4;
      end
      rwac_pkg::WV_M4: begin
        c4_nxt    = mul_q;
        state_nxt = rwac_pkg::WV_M8;
      end
      rwac_pkg::WV_M8: begin
        c8_nxt    = mul_q;
        state_nxt = rwac_pkg::WV_M16;
      end
      rwac_pkg::WV_M16: begin
        c16_nxt   = mul_q;
        state_nxt = rwac_pkg::WV_M20;
      end
      rwac_pkg::WV_M20: begin
        c20_nxt   = mul_q;
        state_nxt = rwac_pkg::WV_ALPHA;
      end
      rwac_pkg::WV_ALPHA: begin
        alpha_nxt = lo + mul_q[7:0];
        done_nxt  = 1'b1;
        state_nxt = rwac_pkg::WV_IDLE;
      end
      default: state_nxt = rwac_pkg::WV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwac_pkg::WV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r     <= h_nxt;
    a_r     <= a_nxt;
    c2_r    <= c2_nxt;
    sh_r    <= sh_nxt;
    c4_r    <= c4_nxt;
    c8_r    <= c8_nxt;
    c16_r   <= c16_nxt;
    c20_r   <= c20_nxt;
    cpos_r  <= cpos_nxt;
    alpha_r <= alpha_nxt;
  end

  assign done  = done_r;
  assign alpha = alpha_r;

endmodule

// ===== hw/rtl/row_wave_alpha_and_contrast.sv =====
// Path: an accepted pixel is registered in the hold stage, then in the output register;
//   a row's first pixel waits in the hold stage until the wave sequencer is done.
// Throughput: one pixel per cycle within a row; the row start stalls input while
//   the single wave sequencer runs, and a stalled output holds the input as well.
// Reset: synchronous active-low rst_n clears counters, row alpha, valids and
//   loads the register defaults; the sine ROM is constant and needs no fill.
`timescale 1ns / 1ps

module row_wave_alpha_and_contrast #(
  parameter int MAX_DIM          = rwac_pkg::DEF_MAX_DIM,
  parameter int SINE_TABLE_DEPTH = rwac_pkg::DEF_SINE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rwac_in_if.sink                     in_pix,
  rwac_out_if.source                  out_pix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rwac_pkg::ADDR_W-1:0] paddr,
  input  logic [rwac_pkg::DATA_W-1:0] pwdata,
  output logic [rwac_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  `include "row_wave_alpha_and_contrast_assert.svh"

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [12:0] d);
    logic [31:0] e;
    if (d == 13'd0)                 e = 32'd1;
    else if (32'(d) > 32'(MAX_DIM)) e = 32'(MAX_DIM);
    else                            e = 32'(d);
    return e[DIM_W-1:0];
  endfunction

  // Contrast about mid grey: ((2v-255)*g + 65280) / 512, clamped to a byte.
  function automatic logic [7:0] contrast(input logic [7:0] v,
                                          input logic [15:0] g);
    logic signed [9:0]  d;
    logic signed [25:0] n;
    d = $signed({1'b0, v, 1'b0}) - 10'sd255;
    n = 26'(d) * 26'($signed(g)) + 26'sd65280;
    if (n < 0)                  return 8'd0;
    else if (n[25:9] > 17'd255) return 8'd255;
    else                        return n[16:9];
  endfunction

  rwac_pkg::cfg_t   cfg;
  logic [DIM_W-1:0] w_eff, h_eff;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [7:0]       alpha_r, alpha_nxt;

  logic             h_valid_r, h_valid_nxt;
  logic             h_wait_r,  h_wait_nxt;
  logic [7:0]       h_red_r, h_green_r, h_blue_r;
  logic             h_eor_r, h_eof_r;

  logic             o_valid_r, o_valid_nxt;
  logic [7:0]       o_alpha_r, o_red_r, o_green_r, o_blue_r;
  logic             o_eor_r, o_eof_r;

  logic             in_accept;
  logic             move;
  logic             eor, eof;
  logic             wave_start;
  logic             wave_done;
  logic [7:0]       wave_alpha;

  rwac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign w_eff = clamp_dim(cfg.frame_width);
  assign h_eff = clamp_dim(cfg.frame_height);

  assign move         = h_valid_r && !h_wait_r && (!o_valid_r || out_pix.ready);
  assign in_pix.ready = !h_valid_r || move;
  assign in_accept    = in_pix.valid && in_pix.ready;
  assign wave_start   = in_accept && (col_r == '0);

  // Counters past a shrunk frame size end the row or frame on the next pixel.
  assign eor = DIM_W'(col_r) >= w_eff - DIM_W'(1);
  assign eof = eor && (DIM_W'(row_r) >= h_eff - DIM_W'(1));

  rwac_wave #(
    .MAX_DIM          (MAX_DIM),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wave_start),
    .row    (row_r),
    .height (h_eff),
    .cfg    (cfg),
    .done   (wave_done),
    .alpha  (wave_alpha)
  );

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    alpha_nxt   = wave_done ? wave_alpha : alpha_r;
    h_valid_nxt = h_valid_r;
    h_wait_nxt  = h_wait_r;
    o_valid_nxt = o_valid_r;
    if (in_accept) begin
      if (eor) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (in_accept)     h_valid_nxt = 1'b1;
    else if (move)     h_valid_nxt = 1'b0;
    if (in_accept)     h_wait_nxt = (col_r == '0);
    else if (wave_done) h_wait_nxt = 1'b0;
    if (move)                 o_valid_nxt = 1'b1;
    else if (out_pix.ready)   o_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      alpha_r   <= 8'd0;
      h_valid_r <= 1'b0;
      h_wait_r  <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      alpha_r   <= alpha_nxt;
      h_valid_r <= h_valid_nxt;
      h_wait_r  <= h_wait_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      h_red_r   <= in_pix.red_in;
      h_green_r <= in_pix.green_in;
      h_blue_r  <= in_pix.blue_in;
      h_eor_r   <= eor;
      h_eof_r   <= eof;
    end
    if (move) begin
      o_alpha_r <= alpha_r;
      o_red_r   <= contrast(h_red_r,   cfg.contrast_gain);
      o_green_r <= contrast(h_green_r, cfg.contrast_gain);
      o_blue_r  <= contrast(h_blue_r,  cfg.contrast_gain);
      o_eor_r   <= h_eor_r;
      o_eof_r   <= h_eof_r;
    end
  end

  assign out_pix.valid        = o_valid_r;
  assign out_pix.alpha_out    = o_alpha_r;
  assign out_pix.red_out      = o_red_r;
  assign out_pix.green_out    = o_green_r;
  assign out_pix.blue_out     = o_blue_r;
  assign out_pix.end_of_row   = o_eor_r;
  assign out_pix.end_of_frame = o_eof_r;

  // A request held for its row alpha must block the input.
  `RWAC_ASSERT_SAME(a_wait_blocks_input, h_wait_r, !in_pix.ready, "input open while waiting")
  `RWAC_ASSERT_SAME(a_done_only_waiting, wave_done, h_valid_r && h_wait_r, "stray wave done")
  `RWAC_ASSERT_NEXT(a_row_start_waits, wave_start, h_wait_r && h_valid_r, "row start not held")

endmodule

// ===== tb/rwac_checker.sv =====
// Pixel stream checker: snoops config writes, predicts every pixel result and compares.
`timescale 1ns / 1ps

module rwac_checker (
  input  logic        clk,
  input  logic        rst_n,
  rwac_in_if          in_mon,
  rwac_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [rwac_pkg::ADDR_W-1:0] paddr,
  input  logic [rwac_pkg::DATA_W-1:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  localparam int ROM_DEPTH = rwac_pkg::DEF_SINE_DEPTH;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
  } pixel_result_t;

  logic [15:0]    quarter_rom [ROM_DEPTH];
  rwac_pkg::cfg_t regs;
  int unsigned    col_pos, row_pos;
  logic [7:0]     row_alpha_q;
  pixel_result_t  expected_q[$];
  int             fail_cnt;

  // quarter-wave table, Taylor series in Q30
  initial begin
    longint unsigned x, term;
    longint          sum, e;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x = (longint'(k) * HALF_PI_Q30) / ROM_DEPTH;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = (sum + 8192) >>> 14;
      if (e > 65535) e = 65535;
      quarter_rom[k] = e[15:0];
    end
  end

  function automatic int quarter_lookup(int unsigned u);
    longint unsigned idx;
    idx = (longint'(u) * ROM_DEPTH) >> 14;
    if (idx >= ROM_DEPTH) return 65536;
    return int'(quarter_rom[idx]);
  endfunction

  function automatic int wave_sine(int unsigned p);
    int unsigned i;
    p = p & 32'hFFFF;
    i = p & 32'h3FFF;
    case (p >> 14)
      0:       return quarter_lookup(i);
      1:       return quarter_lookup(16384 - i);
      2:       return -quarter_lookup(i);
      default: return -quarter_lookup(16384 - i);
    endcase
  endfunction

  function automatic int unsigned clamp_dim(logic [12:0] d);
    if (d == 0) return 1;
    if (d > rwac_pkg::DEF_MAX_DIM) return rwac_pkg::DEF_MAX_DIM;
    return 32'(d);
  endfunction

  function automatic logic [7:0] row_wave_alpha(int unsigned row, int unsigned h);
    longint unsigned pos, w, c2, c4, c8, rng, lo;
    int unsigned a;
    int c;
    pos = (longint'(row) * regs.wave_frequency * 256) / h;
    a = (pos - regs.wave_phase) & 64'hFFFF;
    lo  = (regs.level_a < regs.level_b) ? regs.level_a : regs.level_b;
    rng = (regs.level_a < regs.level_b) ? regs.level_b - regs.level_a
                                        : regs.level_a - regs.level_b;
    c  = wave_sine(a + 16384);
    c2 = longint'(c + 65536) >> 1;
    c4 = (c2 * c2) >> 16;
    c8 = (c4 * c4) >> 16;
    case (regs.wave_shape)
      rwac_pkg::MODE_SINE:   w = longint'(wave_sine(a) + 65536) >> 1;
      rwac_pkg::MODE_COS2:   w = c2;
      rwac_pkg::MODE_COS8:   w = c8;
      rwac_pkg::MODE_COS20:  w = (((c8 * c8) >> 16) * c4) >> 16;
      rwac_pkg::MODE_SQUARE: w = (c > 0) ? 65536 : 0;
      default:               w = 0;
    endcase
    return 8'(lo + ((w * rng) >> 16));
  endfunction

  function automatic logic [7:0] contrast_byte(logic [7:0] v, int g);
    int n;
    n = (2 * int'(v) - 255) * g + 65280;
    if (n < 0) return 8'd0;
    n = n / 512;
    return (n > 255) ? 8'd255 : 8'(n);
  endfunction

  function automatic int field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v === act_v) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    int unsigned w, h;
    int g, bad;
    pixel_result_t exp_r;
    if (!rst_n) begin
      regs = '0;
      regs.frame_width    = 13'd1;
      regs.frame_height   = 13'd1;
      regs.wave_frequency = 16'd256;
      regs.wave_phase     = 16'd0;
      regs.level_a        = 8'd0;
      regs.level_b        = 8'd255;
      regs.contrast_gain  = 16'd256;
      regs.wave_shape     = rwac_pkg::MODE_SINE;
      col_pos = 0;
      row_pos = 0;
      row_alpha_q = '0;
      expected_q.delete();
      fail_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rwac_pkg::reg_index_t'(paddr[4:2]))
          rwac_pkg::REG_FRAME_WIDTH:    regs.frame_width    = pwdata[12:0];
          rwac_pkg::REG_FRAME_HEIGHT:   regs.frame_height   = pwdata[12:0];
          rwac_pkg::REG_WAVE_FREQUENCY: regs.wave_frequency = pwdata[15:0];
          rwac_pkg::REG_WAVE_PHASE:     regs.wave_phase     = pwdata[15:0];
          rwac_pkg::REG_LEVEL_A:        regs.level_a        = pwdata[7:0];
          rwac_pkg::REG_LEVEL_B:        regs.level_b        = pwdata[7:0];
          rwac_pkg::REG_CONTRAST_GAIN:  regs.contrast_gain  = pwdata[15:0];
          rwac_pkg::REG_WAVE_SHAPE:     regs.wave_shape     = pwdata[2:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        w = clamp_dim(regs.frame_width);
        h = clamp_dim(regs.frame_height);
        g = int'(signed'(regs.contrast_gain));
        if (col_pos == 0) row_alpha_q = row_wave_alpha(row_pos, h);
        exp_r.alpha = row_alpha_q;
        exp_r.red   = contrast_byte(in_mon.red_in, g);
        exp_r.green = contrast_byte(in_mon.green_in, g);
        exp_r.blue  = contrast_byte(in_mon.blue_in, g);
        exp_r.eor   = col_pos >= w - 1;
        exp_r.eof   = exp_r.eor && row_pos >= h - 1;
        expected_q.push_back(exp_r);
        // counters left past a shrunk size wrap on the next pixel
        if (exp_r.eor) begin
          col_pos = 0;
          row_pos = exp_r.eof ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected request, expected none got alpha %0d", $time,
                   out_mon.alpha_out);
          fail_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          bad = field_check("alpha_out", exp_r.alpha, out_mon.alpha_out)
              + field_check("red_out", exp_r.red, out_mon.red_out)
              + field_check("green_out", exp_r.green, out_mon.green_out)
              + field_check("blue_out", exp_r.blue, out_mon.blue_out)
              + field_check("end_of_row", 8'(exp_r.eor), 8'(out_mon.end_of_row))
              + field_check("end_of_frame", 8'(exp_r.eof), 8'(out_mon.end_of_frame));
          if (bad != 0) fail_cnt++;
        end
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= expected_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the pixel wave testbench: clock, reset, stimulus, config writes and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rwac_pkg::ADDR_W-1:0] paddr = '0;
  logic [rwac_pkg::DATA_W-1:0] pwdata = '0;
  logic [rwac_pkg::DATA_W-1:0] prdata;
  logic pready;
  int mismatches, outstanding;
  int pixels_sent;
  bit steady_phase;

  rwac_in_if  in_ch ();
  rwac_out_if out_ch ();

  always #2 clk = ~clk;

  row_wave_alpha_and_contrast dut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_ch), .out_pix(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rwac_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .mismatches(mismatches),
    .outstanding(outstanding)
  );

  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  initial begin
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else if (r < 55) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic apb_write(rwac_pkg::reg_index_t idx, logic [31:0] val);
    bit hit;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      hit = pready;
      @(posedge clk);
    end while (!hit);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // the count updates after the edge, so start looking at the next edge
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(logic [12:0] w, logic [12:0] h, logic [15:0] f,
                           logic [15:0] ph, logic [7:0] la, logic [7:0] lb,
                           logic [15:0] g, logic [2:0] m);
    drain();
    apb_write(rwac_pkg::REG_FRAME_WIDTH, 32'(w));
    apb_write(rwac_pkg::REG_FRAME_HEIGHT, 32'(h));
    apb_write(rwac_pkg::REG_WAVE_FREQUENCY, 32'(f));
    apb_write(rwac_pkg::REG_WAVE_PHASE, 32'(ph));
    apb_write(rwac_pkg::REG_LEVEL_A, 32'(la));
    apb_write(rwac_pkg::REG_LEVEL_B, 32'(lb));
    apb_write(rwac_pkg::REG_CONTRAST_GAIN, 32'(g));
    apb_write(rwac_pkg::REG_WAVE_SHAPE, 32'(m));
  endtask

  // entered and left at a rising edge; valid stays high across back-to-back requests
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    bit hit;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    do begin
      @(negedge clk);
      hit = in_ch.ready;
      @(posedge clk);
    end while (!hit);
    pixels_sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127 + 8'($urandom_range(0, 1));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] rand_dim();
    case ($urandom_range(0, 19))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'h1FFF;
      3: return 13'($urandom);
      default: return 13'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'd256;
      3: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n, phase_no;
    in_ch.valid    = 1'b0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    pixels_sent = 0;
    steady_phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: one-pixel frames
    send_pixel(8'd0, 8'd255, 8'd128);
    send_pixel(8'd127, 8'd1, 8'd254);
    end_burst();
    // max positive gain, cos squared, extreme levels
    configure(13'd3, 13'd2, 16'd256, 16'd0, 8'd255, 8'd0, 16'h7FFF, rwac_pkg::MODE_COS2);
    send_pixel(8'd0, 8'd255, 8'd128);
    send_pixel(8'd127, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd254, 8'd64);
    send_pixel(8'd255, 8'd255, 8'd255);
    end_burst();
    // most negative gain, cos^8
    configure(13'd2, 13'd3, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255, 16'h8000, rwac_pkg::MODE_COS8);
    repeat (4) send_pixel(8'd0, 8'd255, 8'd128);
    end_burst();
    // zero gain, zero sizes act as one, cos^20
    configure(13'd0, 13'd0, 16'd0, 16'h8000, 8'd40, 8'd200, 16'd0, rwac_pkg::MODE_COS20);
    repeat (2) send_pixel(8'd255, 8'd0, 8'd127);
    end_burst();
    // oversize dimensions clamp, square wave
    configure(13'h1FFF, 13'h1FFF, 16'd1000, 16'h4000, 8'd10, 8'd10, 16'd512,
              rwac_pkg::MODE_SQUARE);
    repeat (3) send_pixel(8'd200, 8'd50, 8'd5);
    end_burst();
    // unused modes give the smaller level
    configure(13'd1, 13'd4, 16'd700, 16'd0, 8'd90, 8'd30, 16'd256, 3'd5);
    repeat (2) send_pixel(8'd9, 8'd99, 8'd199);
    end_burst();
    configure(13'd1, 13'd4, 16'd700, 16'd0, 8'd90, 8'd30, 16'd256, 3'd7);
    repeat (2) send_pixel(8'd9, 8'd99, 8'd199);
    end_burst();

    phase_no = 0;
    while (pixels_sent < 1100) begin
      configure(rand_dim(), rand_dim(), 16'($urandom), 16'($urandom),
                rand_byte(), rand_byte(), rand_gain(), 3'($urandom_range(0, 7)));
      steady_phase = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      for (int i = 0; i < n; i++) begin
        // hold off mid-burst until every result is back
        if (phase_no == 2 && i == n / 2) begin
          end_burst();
          @(posedge clk);
          while (outstanding != 0) @(posedge clk);
        end
        send_pixel(rand_byte(), rand_byte(), rand_byte());
      end
      end_burst();
      phase_no++;
    end

    drain();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
